// ===== hdl/gimli_sponge_hash_macros.svh =====
// Assertion helpers for the Gimli sponge hash block
`ifndef GIMLI_SPONGE_HASH_MACROS_SVH
`define GIMLI_SPONGE_HASH_MACROS_SVH

// same-cycle implication, disabled during reset
`define GSH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsh check failed");

// next-cycle implication, disabled during reset
`define GSH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsh check failed");

`endif

// ===== hdl/gsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsh_pkg
// Types, constants and the Gimli round function for the sponge hash block.
// ----------------------------------------------------------------------------
package gsh_pkg;

  localparam logic [4:0]  ROUNDS      = 5'd24;
  localparam logic [6:0]  MAX_DIGEST  = 7'd64;
  localparam logic [7:0]  PAD_FIRST   = 8'h1F;
  localparam logic [7:0]  PAD_LAST    = 8'h80;
  localparam logic [3:0]  LAST_RATE   = 4'd15;
  localparam logic [31:0] ROUND_CONST = 32'h9e377900;

  localparam logic        CMD_ABSORB   = 1'b0;
  localparam logic        CMD_FINALIZE = 1'b1;

  typedef logic [11:0][31:0] state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERM,
    ST_OUT
  } fsm_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic permuting;
    logic squeezing;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  // one round; r counts down from ROUNDS to 1
  function automatic state_t gimli_round(input state_t s, input logic [4:0] r);
    state_t      n;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] t;
    n = s;
    for (int col = 0; col < 4; col++) begin
      x = rotl32(s[col], 24);
      y = rotl32(s[4 + col], 9);
      z = s[8 + col];
      n[8 + col] = x ^ (z << 1) ^ ((y & z) << 2);
      n[4 + col] = y ^ x ^ ((x | z) << 1);
      n[col]     = z ^ y ^ ((x & y) << 3);
    end
    if (r[1:0] == 2'd0) begin
      t = n[0]; n[0] = n[1]; n[1] = t;
      t = n[2]; n[2] = n[3]; n[3] = t;
      n[0] = n[0] ^ ROUND_CONST ^ {27'd0, r};
    end else if (r[1:0] == 2'd2) begin
      t = n[0]; n[0] = n[2]; n[2] = t;
      t = n[1]; n[1] = n[3]; n[3] = t;
    end
    return n;
  endfunction

endpackage

// ===== hdl/gsh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsh_in_if / gsh_out_if
// Valid/ready channels for command items and digest bytes.
// ----------------------------------------------------------------------------
interface gsh_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface gsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       last;

  modport source (output valid, digest_byte, last, input ready);
  modport sink   (input valid, digest_byte, last, output ready);
endinterface

// ===== hdl/gsh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsh_front
// Accepts command items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module gsh_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  gsh_in_if.sink               req,
  output gsh_pkg::queue_head_t head,
  input  logic                 pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gsh_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           do_pop;

  assign req.ready = (count != CW'(DEPTH));
  assign push      = req.valid && req.ready;
  assign do_pop    = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{command: req.command, data_byte: req.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/gsh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsh_back
// Sponge state, round-per-cycle permutation and digest squeeze sequencer.
// ----------------------------------------------------------------------------
module gsh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  gsh_pkg::queue_head_t head,
  output logic                 pop,
  input  logic [6:0]           out_len,
  gsh_out_if.source            rsp,
  output gsh_pkg::status_t     stat
);

  gsh_pkg::fsm_t   st, st_next;
  gsh_pkg::state_t sw, sw_next;
  logic [3:0]      offset, offset_next;
  logic [4:0]      rnd, rnd_next;
  logic            after_out, after_out_next;
  logic [5:0]      k, k_next;
  logic [6:0]      len, len_next;
  logic            out_valid, out_valid_next;
  logic [7:0]      out_byte, out_byte_next;
  logic            out_last, out_last_next;
  logic [6:0]      len_sat;
  logic [31:0]     rd_word;
  logic [7:0]      rd_byte;
  logic            is_last;

  assign len_sat = (out_len == 7'd0) ? 7'd1 :
                   (out_len > gsh_pkg::MAX_DIGEST) ? gsh_pkg::MAX_DIGEST : out_len;
  assign rd_word = sw[4'(k[3:2])];
  assign rd_byte = 8'(rd_word >> {k[1:0], 3'b000});
  assign is_last = ((7'(k) + 7'd1) == len);

  assign rsp.valid       = out_valid;
  assign rsp.digest_byte = out_byte;
  assign rsp.last        = out_last;

  assign stat.permuting = (st == gsh_pkg::ST_PERM);
  assign stat.squeezing = (st == gsh_pkg::ST_OUT);

  always_comb begin
    st_next        = st;
    sw_next        = sw;
    offset_next    = offset;
    rnd_next       = rnd;
    after_out_next = after_out;
    k_next         = k;
    len_next       = len;
    out_valid_next = out_valid && !rsp.ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    pop            = 1'b0;
    unique case (st)
      gsh_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.command == gsh_pkg::CMD_ABSORB) begin
            sw_next[4'(offset[3:2])] = sw[4'(offset[3:2])] ^
              (32'(head.item.data_byte) << {offset[1:0], 3'b000});
            offset_next = offset + 4'd1;
            if (offset == gsh_pkg::LAST_RATE) begin
              rnd_next       = gsh_pkg::ROUNDS;
              after_out_next = 1'b0;
              st_next        = gsh_pkg::ST_PERM;
            end
          end else begin
            sw_next[4'(offset[3:2])] = sw[4'(offset[3:2])] ^
              (32'(gsh_pkg::PAD_FIRST) << {offset[1:0], 3'b000});
            sw_next[3] = sw_next[3] ^ {gsh_pkg::PAD_LAST, 24'd0};
            offset_next    = 4'd0;
            len_next       = len_sat;
            k_next         = 6'd0;
            rnd_next       = gsh_pkg::ROUNDS;
            after_out_next = 1'b1;
            st_next        = gsh_pkg::ST_PERM;
          end
        end
      end
      gsh_pkg::ST_PERM: begin
        sw_next  = gsh_pkg::gimli_round(sw, rnd);
        rnd_next = rnd - 5'd1;
        if (rnd == 5'd1) begin
          st_next = after_out ? gsh_pkg::ST_OUT : gsh_pkg::ST_IDLE;
        end
      end
      gsh_pkg::ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_byte_next  = rd_byte;
          out_last_next  = is_last;
          k_next         = k + 6'd1;
          if (is_last) begin
            sw_next     = '0;
            offset_next = 4'd0;
            st_next     = gsh_pkg::ST_IDLE;
          end else if (k[3:0] == gsh_pkg::LAST_RATE) begin
            rnd_next       = gsh_pkg::ROUNDS;
            after_out_next = 1'b1;
            st_next        = gsh_pkg::ST_PERM;
          end
        end
      end
      default: st_next = gsh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= gsh_pkg::ST_IDLE;
      sw        <= '0;
      offset    <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      sw        <= sw_next;
      offset    <= offset_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rnd       <= rnd_next;
    after_out <= after_out_next;
    k         <= k_next;
    len       <= len_next;
    out_byte  <= out_byte_next;
    out_last  <= out_last_next;
  end

endmodule

// ===== hdl/gimli_sponge_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimli_sponge_hash
// Gimli sponge hash: absorbs message bytes, squeezes a digest on finalize.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command items: command 0 absorbs data_byte, command 1 pads,
//   permutes and squeezes out_len digest bytes (0 acts as 1, above 64 as 64).
//   rsp carries one item per digest byte; last marks the final one.
//   cfg_we/cfg_data write out_len (reset 32); write it only while idle.
// Timing:
//   Items pass a QUEUE_DEPTH-entry queue into the sponge sequencer.
//   Every 16th absorb starts the permutation, which runs one round per
//   cycle. A finalize pads and permutes, then sends one byte per cycle
//   while rsp is ready, with a permutation between 16-byte blocks.
// Reset clears the sponge, the queue and the output valid flag at once.
// When rsp stalls, the sequencer holds the next byte and the queue keeps
// taking items until it is full.
// ----------------------------------------------------------------------------
`include "gimli_sponge_hash_macros.svh"

module gimli_sponge_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  gsh_in_if.sink     req,
  gsh_out_if.source  rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  gsh_pkg::queue_head_t head;
  gsh_pkg::status_t     stat;
  logic                 q_pop;
  logic [6:0]           out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_len <= 7'd32;
    end else if (cfg_we) begin
      out_len <= cfg_data;
    end
  end

  gsh_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (q_pop)
  );

  gsh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (q_pop),
    .out_len (out_len),
    .rsp     (rsp),
    .stat    (stat)
  );

  `GSH_ASSERT_NXT(a_accept_queued, clk, rst, req.valid && req.ready, head.valid)
  `GSH_ASSERT_IMP(a_no_pop_in_perm, clk, rst, stat.permuting, !q_pop)
  `GSH_ASSERT_IMP(a_out_from_squeeze, clk, rst, $rose(rsp.valid), $past(stat.squeezing))

endmodule
